// ===== rtl/lswc_pkg.sv =====
// ----------------------------------------------------------------------------
// lswc_pkg: shared definitions for the line segment window clipper
// Default coordinate width, window register indexes and window reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lswc_pkg;

  // Default coordinate width of all endpoint and window fields
  localparam int COORD_WIDTH_DEF = 16;

  // Configuration register index width
  localparam int CFG_IDX_W = 2;

  // Window register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XMIN = 2'd0,
    REG_XMAX = 2'd1,
    REG_YMIN = 2'd2,
    REG_YMAX = 2'd3
  } cfg_reg_e;

  // Window reset values
  localparam int XMIN_RESET = 0;
  localparam int XMAX_RESET = 639;
  localparam int YMIN_RESET = 0;
  localparam int YMAX_RESET = 479;

endpackage : lswc_pkg

`default_nettype wire

// ===== rtl/lswc_ifs.sv =====
// ----------------------------------------------------------------------------
// lswc_ifs: channel interfaces of the line segment window clipper
// Segment input, clip result output and window register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Segment word: two endpoints
interface lswc_seg_if #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface : lswc_seg_if

// Result word: accept flag and clipped endpoints
interface lswc_res_if #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic signed [COORD_WIDTH-1:0] clip_start_x;
  logic signed [COORD_WIDTH-1:0] clip_start_y;
  logic signed [COORD_WIDTH-1:0] clip_end_x;
  logic signed [COORD_WIDTH-1:0] clip_end_y;

  modport source (output valid, accepted, clip_start_x, clip_start_y,
                  clip_end_x, clip_end_y, input ready);
  modport sink   (input valid, accepted, clip_start_x, clip_start_y,
                  clip_end_x, clip_end_y, output ready);
endinterface : lswc_res_if

// Window register write word
interface lswc_cfg_if #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [lswc_pkg::CFG_IDX_W-1:0]  index;
  logic [COORD_WIDTH-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : lswc_cfg_if

`default_nettype wire

// ===== rtl/line_segment_window_clipper.sv =====
// ----------------------------------------------------------------------------
// line_segment_window_clipper: region-code line clipper, top level
// Clips one segment against the window registers by repeated region-code
// tests and endpoint moves, each move run on the shared interpolation unit.
// ----------------------------------------------------------------------------
//  channel   direction  word contents
//  seg_i     in         start_x, start_y, end_x, end_y
//  clip_o    out        accepted, clip_start_x, clip_start_y, clip_end_x,
//                       clip_end_y
//  cfg_i     in         index (window register), data
//
//  One segment at a time: seg_i.ready is high only while the block is idle.
//  Each endpoint move runs on the bit-serial divide of the interpolation
//  unit; a segment makes at most eight moves.
//  The result word holds on clip_o until taken; the next segment is
//  accepted after that. Reset loads the default window.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_window_clipper #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lswc_seg_if.sink   seg_i,
  lswc_res_if.source clip_o,
  lswc_cfg_if.sink   cfg_i
);

  import lswc_pkg::*;

  localparam int W         = COORD_WIDTH;
  localparam int MoveLimit = 8;
  localparam int MoveW     = $clog2(MoveLimit + 1);

  // Region code bits
  localparam logic [3:0] OcLeft   = 4'b0001;
  localparam logic [3:0] OcRight  = 4'b0010;
  localparam logic [3:0] OcBottom = 4'b0100;
  localparam logic [3:0] OcTop    = 4'b1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic signed [W-1:0]   xmin_q, xmin_d;
  logic signed [W-1:0]   xmax_q, xmax_d;
  logic signed [W-1:0]   ymin_q, ymin_d;
  logic signed [W-1:0]   ymax_q, ymax_d;
  logic signed [W-1:0]   sx_q, sx_d;
  logic signed [W-1:0]   sy_q, sy_d;
  logic signed [W-1:0]   ex_q, ex_d;
  logic signed [W-1:0]   ey_q, ey_d;
  logic [MoveW-1:0]      moves_q, moves_d;
  logic                  acc_q, acc_d;
  logic signed [W-1:0]   base_q, base_d;
  logic signed [W:0]     delta_q, delta_d;
  logic signed [W:0]     num_q, num_d;
  logic signed [W:0]     den_q, den_d;
  logic signed [W-1:0]   fix_q, fix_d;
  logic                  fix_x_q, fix_x_d;
  logic                  mv_start_q, mv_start_d;
  logic                  start_q, start_d;

  logic [3:0]            c1;
  logic [3:0]            c2;
  logic [3:0]            csel;
  logic signed [W:0]     dx;
  logic signed [W:0]     dy;
  logic signed [W-1:0]   nx;
  logic signed [W-1:0]   ny;
  logic                  ip_done;
  logic signed [W-1:0]   ip_result;

  function automatic logic signed [W:0] sext(input logic signed [W-1:0] v);
    return {v[W-1], v};
  endfunction

  // Region codes of both endpoints
  always_comb begin
    c1 = '0;
    if (sx_q < xmin_q) c1 = c1 | OcLeft;
    if (sx_q > xmax_q) c1 = c1 | OcRight;
    if (sy_q < ymin_q) c1 = c1 | OcBottom;
    if (sy_q > ymax_q) c1 = c1 | OcTop;
    c2 = '0;
    if (ex_q < xmin_q) c2 = c2 | OcLeft;
    if (ex_q > xmax_q) c2 = c2 | OcRight;
    if (ey_q < ymin_q) c2 = c2 | OcBottom;
    if (ey_q > ymax_q) c2 = c2 | OcTop;
  end

  assign csel = (c1 != '0) ? c1 : c2;
  assign dx   = sext(ex_q) - sext(sx_q);
  assign dy   = sext(ey_q) - sext(sy_q);

  // New point of the moving endpoint
  assign nx = fix_x_q ? fix_q : ip_result;
  assign ny = fix_x_q ? ip_result : fix_q;

  always_comb begin
    state_d    = state_q;
    xmin_d     = xmin_q;
    xmax_d     = xmax_q;
    ymin_d     = ymin_q;
    ymax_d     = ymax_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    ex_d       = ex_q;
    ey_d       = ey_q;
    moves_d    = moves_q;
    acc_d      = acc_q;
    base_d     = base_q;
    delta_d    = delta_q;
    num_d      = num_q;
    den_d      = den_q;
    fix_d      = fix_q;
    fix_x_d    = fix_x_q;
    mv_start_d = mv_start_q;
    start_d    = 1'b0;

    // Window register writes
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_XMIN: xmin_d = cfg_i.data;
        REG_XMAX: xmax_d = cfg_i.data;
        REG_YMIN: ymin_d = cfg_i.data;
        REG_YMAX: ymax_d = cfg_i.data;
        default:  xmin_d = xmin_q;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        // Take a new segment
        if (seg_i.valid) begin
          sx_d    = seg_i.start_x;
          sy_d    = seg_i.start_y;
          ex_d    = seg_i.end_x;
          ey_d    = seg_i.end_y;
          moves_d = '0;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if ((c1 | c2) == '0) begin
          acc_d   = 1'b1;
          state_d = ST_DONE;
        end else if (((c1 & c2) != '0) || (moves_q == MoveW'(MoveLimit))) begin
          acc_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          // Pick the edge to move onto: top, bottom, right, left
          mv_start_d = (c1 != '0);
          if ((csel & OcTop) != '0) begin
            base_d  = sx_q;
            delta_d = dx;
            num_d   = sext(ymax_q) - sext(sy_q);
            den_d   = dy;
            fix_d   = ymax_q;
            fix_x_d = 1'b0;
          end else if ((csel & OcBottom) != '0) begin
            base_d  = sx_q;
            delta_d = dx;
            num_d   = sext(ymin_q) - sext(sy_q);
            den_d   = dy;
            fix_d   = ymin_q;
            fix_x_d = 1'b0;
          end else if ((csel & OcRight) != '0) begin
            base_d  = sy_q;
            delta_d = dy;
            num_d   = sext(xmax_q) - sext(sx_q);
            den_d   = dx;
            fix_d   = xmax_q;
            fix_x_d = 1'b1;
          end else begin
            base_d  = sy_q;
            delta_d = dy;
            num_d   = sext(xmin_q) - sext(sx_q);
            den_d   = dx;
            fix_d   = xmin_q;
            fix_x_d = 1'b1;
          end
          moves_d = moves_q + 1'b1;
          start_d = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Write the moved endpoint back and test again
        if (ip_done) begin
          if (mv_start_q) begin
            sx_d = nx;
            sy_d = ny;
          end else begin
            ex_d = nx;
            ey_d = ny;
          end
          state_d = ST_TEST;
        end
      end
      ST_DONE: begin
        if (clip_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      xmin_q     <= W'(XMIN_RESET);
      xmax_q     <= W'(XMAX_RESET);
      ymin_q     <= W'(YMIN_RESET);
      ymax_q     <= W'(YMAX_RESET);
      moves_q    <= '0;
      acc_q      <= 1'b0;
      start_q    <= 1'b0;
      mv_start_q <= 1'b0;
      fix_x_q    <= 1'b0;
      sx_q       <= '0;
      sy_q       <= '0;
      ex_q       <= '0;
      ey_q       <= '0;
      base_q     <= '0;
      delta_q    <= '0;
      num_q      <= '0;
      den_q      <= '0;
      fix_q      <= '0;
    end else begin
      state_q    <= state_d;
      xmin_q     <= xmin_d;
      xmax_q     <= xmax_d;
      ymin_q     <= ymin_d;
      ymax_q     <= ymax_d;
      moves_q    <= moves_d;
      acc_q      <= acc_d;
      start_q    <= start_d;
      mv_start_q <= mv_start_d;
      fix_x_q    <= fix_x_d;
      sx_q       <= sx_d;
      sy_q       <= sy_d;
      ex_q       <= ex_d;
      ey_q       <= ey_d;
      base_q     <= base_d;
      delta_q    <= delta_d;
      num_q      <= num_d;
      den_q      <= den_d;
      fix_q      <= fix_d;
    end
  end

  // Shared multiply and divide unit
  lswc_interp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .base_i   (base_q),
    .delta_i  (delta_q),
    .num_i    (num_q),
    .den_i    (den_q),
    .done_o   (ip_done),
    .result_o (ip_result)
  );

  // Handshakes and result word
  assign seg_i.ready         = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign clip_o.valid        = (state_q == ST_DONE);
  assign clip_o.accepted     = acc_q;
  assign clip_o.clip_start_x = acc_q ? sx_q : '0;
  assign clip_o.clip_start_y = acc_q ? sy_q : '0;
  assign clip_o.clip_end_x   = acc_q ? ex_q : '0;
  assign clip_o.clip_end_y   = acc_q ? ey_q : '0;

endmodule : line_segment_window_clipper

`default_nettype wire

// ===== rtl/lswc_interp.sv =====
// ----------------------------------------------------------------------------
// lswc_interp: shared interpolation unit
// Computes base + trunc(delta * num / den) with one registered multiply and
// a restoring divide that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lswc_interp #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_WIDTH-1:0] base_i,
  input  logic signed [COORD_WIDTH:0]   delta_i,
  input  logic signed [COORD_WIDTH:0]   num_i,
  input  logic signed [COORD_WIDTH:0]   den_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] result_o
);

  localparam int DW       = COORD_WIDTH + 1;
  localparam int PW       = 2 * DW;
  localparam int DivSteps = PW;
  localparam int CntW     = $clog2(DivSteps + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [COORD_WIDTH-1:0]  base_q, base_d;
  logic [DW-1:0]           dmag_q, dmag_d;
  logic [DW-1:0]           nmag_q, nmag_d;
  logic [DW-1:0]           den_q, den_d;
  logic                    neg_q, neg_d;
  logic                    den_zero_q, den_zero_d;
  logic [PW-1:0]           pq_q, pq_d;
  logic [DW-1:0]           rem_q, rem_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [COORD_WIDTH-1:0]  result_q, result_d;

  logic [DW:0]             rem_sh;
  logic [DW:0]             rem_sub;
  logic                    rem_ge;
  logic [DW-1:0]           base_ext;
  logic [DW-1:0]           quot;
  logic [DW-1:0]           sum;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : v;
  endfunction

  // One restoring divide step
  assign rem_sh  = {rem_q, pq_q[PW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_ge  = (rem_sh >= {1'b0, den_q});

  // Apply sign and add to the base point
  assign base_ext = {base_q[COORD_WIDTH-1], base_q};
  assign quot     = pq_q[DW-1:0];
  assign sum      = neg_q ? (base_ext - quot) : (base_ext + quot);

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    dmag_d     = dmag_q;
    nmag_d     = nmag_q;
    den_d      = den_q;
    neg_d      = neg_q;
    den_zero_d = den_zero_q;
    pq_d       = pq_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    done_d     = 1'b0;
    result_d   = result_q;

    unique case (state_q)
      ST_IDLE: begin
        // Capture operands as magnitudes and a result sign
        if (start_i) begin
          base_d     = base_i;
          dmag_d     = mag(delta_i);
          nmag_d     = mag(num_i);
          den_d      = mag(den_i);
          neg_d      = delta_i[DW-1] ^ num_i[DW-1] ^ den_i[DW-1];
          den_zero_d = (den_i == '0);
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        pq_d    = PW'(dmag_q * nmag_q);
        rem_d   = '0;
        cnt_d   = CntW'(DivSteps);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Shift in one dividend bit, retire one quotient bit
        rem_d = rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        pq_d  = {pq_q[PW-2:0], rem_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        result_d = den_zero_q ? base_q : sum[COORD_WIDTH-1:0];
        done_d   = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      result_q   <= '0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      result_q   <= result_d;
    end
  end

  // Operand and datapath registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    dmag_q     <= dmag_d;
    nmag_q     <= nmag_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    den_zero_q <= den_zero_d;
    pq_q       <= pq_d;
    rem_q      <= rem_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule : lswc_interp

`default_nettype wire
